>>> rtl/tass_pkg.sv
// Shared types and constants for the truss adjacency store.
// No dependencies; imported by every module of the block.
package tass_pkg;

    localparam int FIELD_W = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] lbl;
        logic [FIELD_W-1:0] nb;
    } entry_t;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_NEW  = 2'd1;
    localparam logic [1:0] MODE_MAX  = 2'd2;
    localparam logic [1:0] MODE_PURE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    localparam logic [FIELD_W-1:0] NEW_EDGE_BONUS = 10'd10;
    localparam logic [FIELD_W-1:0] LOAD_OFFSET    = 10'd2;
    localparam logic [FIELD_W-1:0] FIELD_MAX      = 10'd1023;
    localparam logic [6:0]         COUNT_LIMIT    = 7'd127;

endpackage

>>> rtl/tass_adj_mem.sv
// Neighbour and label storage: one write port, one registered read port.
// Depends on tass_pkg for the slot entry type.
module tass_adj_mem
    import tass_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/truss_adjacency_store_support_core.sv
// Top level of the truss adjacency store with triangle support counting.
// Depends on tass_pkg and tass_adj_mem.
//
// Channel     | Dir | Handshake                    | Contents
// s_axis      | in  | s_axis_tvalid/s_axis_tready  | tuser: mode; tdata: vertex_a, vertex_b,
//             |     |                              |   truss_number
// m_axis      | out | m_axis_tvalid/m_axis_tready  | tuser: status; tdata: support_count
// cfg         | in  | cfg_we (no back-pressure)    | cfg_wdata: max_truss_label
//
// Sequencing: one transaction at a time through a sequencer around a single-read
// memory port. An insert shifts neighbours not below the new one up slot by slot in
// each list; a maximum-degree query walks both lists in one merge; a pure query adds
// a nested merge for each tied common neighbour.
// Reset: after rst_n is released the list lengths are cleared, one vertex a
// cycle, for MAX_VERTICES cycles; s_axis_tready stays low meanwhile.
// Stalls: a result waits in the output register; a new transaction may be taken
// while it waits, and the sequencer holds its next result until it is taken.
module truss_adjacency_store_support_core
    import tass_pkg::*;
#(
    parameter int MAX_VERTICES     = 1024,
    parameter int SLOTS_PER_VERTEX = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [9:0] vertex_a, [19:10] vertex_b,
                                        // [29:20] truss_number, [31:30] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] support_count, [7] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata
);

    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = $clog2(SLOTS_PER_VERTEX);
    localparam int LW = $clog2(SLOTS_PER_VERTEX + 1);
    localparam int AW = VW + SW;
    localparam int DEPTH = MAX_VERTICES * (2 ** SW);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_LA   = 5'd2;
    localparam logic [4:0] S_LB   = 5'd3;
    localparam logic [4:0] S_CHK  = 5'd4;
    localparam logic [4:0] S_PT   = 5'd5;
    localparam logic [4:0] S_PC   = 5'd6;
    localparam logic [4:0] S_PP   = 5'd7;
    localparam logic [4:0] S_PL   = 5'd8;
    localparam logic [4:0] S_PL2  = 5'd9;
    localparam logic [4:0] S_SR   = 5'd10;
    localparam logic [4:0] S_SC   = 5'd11;
    localparam logic [4:0] S_MX   = 5'd12;
    localparam logic [4:0] S_MY   = 5'd13;
    localparam logic [4:0] S_MC   = 5'd14;
    localparam logic [4:0] S_IL   = 5'd15;
    localparam logic [4:0] S_IL2  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    logic [4:0] state_reg, state_next;
    logic [VW-1:0] clr_reg;

    // configuration
    logic [9:0] mtl_reg;

    // captured transaction
    logic [1:0] mode_reg;
    logic [9:0] a_reg, b_reg, tn_reg;

    // insert datapath
    logic [LW-1:0] lena_reg, lenb_reg, lenv_reg, pos_reg;
    logic [VW-1:0] v_reg;
    logic [9:0]    nb_reg, label_reg;
    logic          phase_reg;

    // query datapath
    logic [LW-1:0] s_reg, i_reg, j_reg, i2_reg, j2_reg, lenu2_reg, lenw2_reg;
    logic [LW-1:0] cnt_reg, cnt2_reg;
    logic [VW-1:0] u2_reg;
    logic [9:0]    k_reg, xo_reg, lao_reg, xi_reg, lai_reg;
    logic          level_reg, pend_reg;

    // result and output register
    logic [1:0] res_status_reg;
    logic [6:0] res_count_reg;
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic [6:0] out_count_reg;

    // memories
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata, mem_rdata;
    logic [LW-1:0] len_mem [MAX_VERTICES];
    logic [LW-1:0] len_rdata_reg;
    logic          len_we;
    logic [VW-1:0] len_waddr, len_raddr;
    logic [LW-1:0] len_wdata;

    tass_adj_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_rdata_reg <= len_mem[len_raddr];
    end

    // derived values
    logic [VW-1:0] a_v, b_v;
    logic          in_range;
    logic [1:0]    need;
    logic          room_ok;
    logic [9:0]    new_label;
    logic [10:0]   bonus_sum;
    logic          s_accept;

    logic [VW-1:0] cur_u, cur_w;
    logic [LW-1:0] cur_i, cur_j, cur_lu, cur_lw;
    logic          merge_end;
    logic [9:0]    cur_x, cur_lx, lo;
    logic          inner_hit;

    assign a_v      = VW'(a_reg);
    assign b_v      = VW'(b_reg);
    assign in_range = (32'(a_reg) < MAX_VERTICES) && (32'(b_reg) < MAX_VERTICES);
    assign need     = (a_reg == b_reg) ? 2'd2 : 2'd1;
    assign room_ok  = (32'(lena_reg) + 32'(need) <= SLOTS_PER_VERTEX)
                   && (32'(len_rdata_reg) + 32'(need) <= SLOTS_PER_VERTEX);
    assign bonus_sum = {1'b0, mtl_reg} + {1'b0, NEW_EDGE_BONUS};

    always_comb
    begin
        if (mode_reg == MODE_LOAD)
        begin
            new_label = (tn_reg >= LOAD_OFFSET) ? (tn_reg - LOAD_OFFSET) : '0;
        end
        else
        begin
            new_label = bonus_sum[10] ? FIELD_MAX : bonus_sum[9:0];
        end
    end

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // the merge walks list a against list b, or a nested list against its neighbour
    assign cur_u  = level_reg ? u2_reg : a_v;
    assign cur_w  = level_reg ? VW'(xo_reg) : b_v;
    assign cur_i  = level_reg ? i2_reg : i_reg;
    assign cur_j  = level_reg ? j2_reg : j_reg;
    assign cur_lu = level_reg ? lenu2_reg : lena_reg;
    assign cur_lw = level_reg ? lenw2_reg : lenb_reg;
    assign cur_x  = level_reg ? xi_reg : xo_reg;
    assign cur_lx = level_reg ? lai_reg : lao_reg;
    assign merge_end = (cur_i == cur_lu) || (cur_j == cur_lw);
    assign lo = (cur_lx < mem_rdata.lbl) ? cur_lx : mem_rdata.lbl;
    assign inner_hit = 32'(cnt2_reg) > 32'(k_reg);

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = {v_reg, pos_reg[SW-1:0]};
        mem_wdata = mem_rdata;
        mem_raddr = {cur_u, cur_i[SW-1:0]};
        len_we    = 1'b0;
        len_waddr = v_reg;
        len_wdata = lenv_reg + 1'b1;
        len_raddr = a_v;
        unique case (state_reg)
            S_CLR:
            begin
                len_we    = 1'b1;
                len_waddr = clr_reg;
                len_wdata = '0;
            end
            S_LB:    len_raddr = b_v;
            S_PT:    mem_raddr = {v_reg, pos_reg[SW-1:0] - 1'b1};
            S_PC:    mem_we = (mem_rdata.nb >= nb_reg);
            S_PP:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{lbl: label_reg, nb: nb_reg};
                len_we    = 1'b1;
            end
            S_PL:    len_raddr = v_reg;
            S_SR:    mem_raddr = {a_v, s_reg[SW-1:0]};
            S_MY:    mem_raddr = {cur_w, cur_j[SW-1:0]};
            S_IL:    len_raddr = VW'(xo_reg);
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_reg == VW'(MAX_VERTICES - 1)) state_next = S_IDLE;
            S_IDLE: if (s_accept) state_next = S_LA;
            S_LA:   state_next = S_LB;
            S_LB:   state_next = S_CHK;
            S_CHK:
            begin
                if (!in_range)                state_next = S_OUT;
                else if (mode_reg[1])         state_next = S_SR;
                else if (room_ok)             state_next = S_PT;
                else                          state_next = S_OUT;
            end
            S_PT:   state_next = (pos_reg == '0) ? S_PP : S_PC;
            S_PC:   state_next = (mem_rdata.nb >= nb_reg) ? S_PT : S_PP;
            S_PP:   state_next = phase_reg ? S_OUT : S_PL;
            S_PL:   state_next = S_PL2;
            S_PL2:  state_next = S_PT;
            S_SR:   state_next = (s_reg == lena_reg) ? S_OUT : S_SC;
            S_SC:   state_next = (mem_rdata.nb == b_reg) ? S_MX : S_SR;
            S_MX:
            begin
                if (!merge_end)                          state_next = S_MY;
                else if (!level_reg)                     state_next = S_OUT;
                else if (inner_hit && pend_reg)          state_next = S_IL;
                else                                     state_next = S_MX;
            end
            S_MY:   state_next = S_MC;
            S_MC:
            begin
                state_next = S_MX;
                if (!level_reg && mode_reg == MODE_PURE && cur_x == mem_rdata.nb
                    && lo == k_reg)
                begin
                    state_next = S_IL;
                end
            end
            S_IL:   state_next = S_IL2;
            S_IL2:  state_next = S_MX;
            S_OUT:  if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default: state_next = S_CLR;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            mtl_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                mtl_reg <= cfg_wdata;
            end
            if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    mode_reg <= s_axis_tuser;
                    a_reg    <= s_axis_tdata[9:0];
                    b_reg    <= s_axis_tdata[19:10];
                    tn_reg   <= s_axis_tdata[29:20];
                end
                res_status_reg <= ST_OK;
                res_count_reg  <= '0;
            end
            S_LB:   lena_reg <= len_rdata_reg;
            S_CHK:
            begin
                lenb_reg  <= len_rdata_reg;
                label_reg <= new_label;
                v_reg     <= a_v;
                nb_reg    <= b_reg;
                pos_reg   <= lena_reg;
                lenv_reg  <= lena_reg;
                phase_reg <= 1'b0;
                s_reg     <= '0;
                if (!in_range)
                begin
                    res_status_reg <= mode_reg[1] ? ST_MISSING : ST_FULL;
                end
                else if (!mode_reg[1] && !room_ok)
                begin
                    res_status_reg <= ST_FULL;
                end
            end
            S_PC:
            begin
                if (mem_rdata.nb >= nb_reg)
                begin
                    pos_reg <= pos_reg - 1'b1;
                end
            end
            S_PP:
            begin
                phase_reg <= 1'b1;
                v_reg     <= b_v;
                nb_reg    <= a_reg;
            end
            S_PL2:
            begin
                pos_reg  <= len_rdata_reg;
                lenv_reg <= len_rdata_reg;
            end
            S_SR:
            begin
                if (s_reg == lena_reg)
                begin
                    res_status_reg <= ST_MISSING;
                end
            end
            S_SC:
            begin
                k_reg     <= mem_rdata.lbl;
                i_reg     <= '0;
                j_reg     <= '0;
                cnt_reg   <= '0;
                level_reg <= 1'b0;
                pend_reg  <= 1'b0;
                if (mem_rdata.nb != b_reg)
                begin
                    s_reg <= s_reg + 1'b1;
                end
            end
            S_MX:
            begin
                if (merge_end && level_reg)
                begin
                    if (inner_hit && pend_reg)
                    begin
                        // tied labels: the side edge at b must pass as well
                        pend_reg  <= 1'b0;
                        u2_reg    <= b_v;
                        lenu2_reg <= lenb_reg;
                    end
                    else
                    begin
                        level_reg <= 1'b0;
                        i_reg     <= i_reg + 1'b1;
                        j_reg     <= j_reg + 1'b1;
                        if (inner_hit)
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                end
                else if (merge_end)
                begin
                    res_count_reg <= (32'(cnt_reg) > 32'(COUNT_LIMIT))
                                   ? COUNT_LIMIT : 7'(cnt_reg);
                end
            end
            S_MY:
            begin
                if (level_reg)
                begin
                    xi_reg  <= mem_rdata.nb;
                    lai_reg <= mem_rdata.lbl;
                end
                else
                begin
                    xo_reg  <= mem_rdata.nb;
                    lao_reg <= mem_rdata.lbl;
                end
            end
            S_MC:
            begin
                if (level_reg)
                begin
                    if (cur_x == mem_rdata.nb)
                    begin
                        if (lo >= k_reg)
                        begin
                            cnt2_reg <= cnt2_reg + 1'b1;
                        end
                        i2_reg <= i2_reg + 1'b1;
                        j2_reg <= j2_reg + 1'b1;
                    end
                    else if (cur_x < mem_rdata.nb)
                    begin
                        i2_reg <= i2_reg + 1'b1;
                    end
                    else
                    begin
                        j2_reg <= j2_reg + 1'b1;
                    end
                end
                else if (cur_x == mem_rdata.nb)
                begin
                    if (mode_reg == MODE_PURE && lo == k_reg)
                    begin
                        // hold the outer step; check the side edge with the lower label
                        u2_reg    <= (mem_rdata.lbl < lao_reg) ? b_v : a_v;
                        lenu2_reg <= (mem_rdata.lbl < lao_reg) ? lenb_reg : lena_reg;
                        pend_reg  <= (mem_rdata.lbl == lao_reg);
                    end
                    else
                    begin
                        if ((mode_reg == MODE_MAX && lo >= k_reg)
                            || (mode_reg == MODE_PURE && lo > k_reg))
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        i_reg <= i_reg + 1'b1;
                        j_reg <= j_reg + 1'b1;
                    end
                end
                else if (cur_x < mem_rdata.nb)
                begin
                    i_reg <= i_reg + 1'b1;
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end
            S_IL2:
            begin
                lenw2_reg <= len_rdata_reg;
                i2_reg    <= '0;
                j2_reg    <= '0;
                cnt2_reg  <= '0;
                level_reg <= 1'b1;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_status_reg <= res_status_reg;
                    out_count_reg  <= res_count_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg};

`ifndef SYNTH
    // no transaction is taken while the sequencer is busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input taken while busy");

    // only defined status codes leave the block
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_FULL
                           || m_axis_tuser == ST_MISSING))
        else $error("undefined status");

    // a count is reported only with a good status
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata != 8'd0) |-> (m_axis_tuser == ST_OK))
        else $error("count with error status");
`endif

endmodule

>>> tb/tb_truss_adjacency_store_support_core.sv
// Self-checking testbench for truss_adjacency_store_support_core.
// Depends on tass_pkg and the RTL of the block; carries its own model of the store.
`timescale 1ns / 1ps

module tb_truss_adjacency_store_support_core;
    import tass_pkg::*;

    localparam int NVERT      = 1024;
    localparam int NSLOT      = 64;
    localparam int HALF_CLK   = 6;
    localparam int CYCLE_CAP  = 6000000;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 160;

    // Expected outcome of one transaction on the result side.
    typedef struct {
        logic [1:0] status;
        logic [6:0] support;
    } outcome_t;

    // Scoreboard: a copy of the adjacency store plus the queue of outcomes still owed.
    class support_board;
        logic [9:0] nbr [NVERT][NSLOT];
        logic [9:0] lbl [NVERT][NSLOT];
        int         len [NVERT];
        logic [9:0] max_label;
        outcome_t   owed [$];
        int         errors;

        function void clear();
            foreach (len[v])
                len[v] = 0;
            max_label = '0;
            errors    = 0;
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        // Insert nb into the sorted list of v, before any equal neighbours.
        function void place(int v, logic [9:0] nb, logic [9:0] lab);
            int pos;
            pos = len[v];
            while (pos > 0 && nbr[v][pos-1] >= nb) begin
                nbr[v][pos] = nbr[v][pos-1];
                lbl[v][pos] = lbl[v][pos-1];
                pos--;
            end
            nbr[v][pos] = nb;
            lbl[v][pos] = lab;
            len[v]++;
        endfunction

        // Common neighbours w of the edge at slot s of u with both side labels >= its label.
        function int max_deg(int u, int s);
            int w, k, i, j, cnt, la, lb;
            w = nbr[u][s];
            k = lbl[u][s];
            i = 0; j = 0; cnt = 0;
            while (i < len[u] && j < len[w]) begin
                if (nbr[u][i] == nbr[w][j]) begin
                    la = lbl[u][i];
                    lb = lbl[w][j];
                    if ((la < lb ? la : lb) >= k)
                        cnt++;
                    i++; j++;
                end
                else if (nbr[u][i] < nbr[w][j])
                    i++;
                else
                    j++;
            end
            return cnt;
        endfunction

        function int pure_deg(int a, int s);
            int b, k, i, j, cnt, la, lb, lo;
            b = nbr[a][s];
            k = lbl[a][s];
            i = 0; j = 0; cnt = 0;
            while (i < len[a] && j < len[b]) begin
                if (nbr[a][i] == nbr[b][j]) begin
                    la = lbl[a][i];
                    lb = lbl[b][j];
                    lo = la < lb ? la : lb;
                    if (lo > k)
                        cnt++;
                    else if (lo == k) begin
                        if (la < lb) begin
                            if (max_deg(a, i) > k) cnt++;
                        end
                        else if (lb < la) begin
                            if (max_deg(b, j) > k) cnt++;
                        end
                        else if (max_deg(a, i) > k && max_deg(b, j) > k)
                            cnt++;
                    end
                    i++; j++;
                end
                else if (nbr[a][i] < nbr[b][j])
                    i++;
                else
                    j++;
            end
            return cnt;
        endfunction

        // Note an accepted input transaction and queue its outcome.
        function void note(logic [1:0] mode, logic [9:0] a, logic [9:0] b, logic [9:0] tn);
            outcome_t   res;
            int         need, s, cnt;
            logic [10:0] wide;
            logic [9:0] lab;
            bit         found;
            res.status  = ST_OK;
            res.support = '0;
            if (mode == MODE_LOAD || mode == MODE_NEW) begin
                need = (a == b) ? 2 : 1;
                if (len[a] + need > NSLOT || len[b] + need > NSLOT)
                    res.status = ST_FULL;
                else begin
                    if (mode == MODE_LOAD)
                        lab = (tn >= LOAD_OFFSET) ? tn - LOAD_OFFSET : '0;
                    else begin
                        wide = max_label + NEW_EDGE_BONUS;
                        lab  = (wide > FIELD_MAX) ? FIELD_MAX : wide[9:0];
                    end
                    place(a, b, lab);
                    place(b, a, lab);
                end
            end
            else begin
                found = 0;
                for (s = 0; s < len[a]; s++)
                    if (nbr[a][s] == b) begin
                        found = 1;
                        break;
                    end
                if (!found)
                    res.status = ST_MISSING;
                else begin
                    cnt = (mode == MODE_MAX) ? max_deg(a, s) : pure_deg(a, s);
                    res.support = (cnt > COUNT_LIMIT) ? COUNT_LIMIT : cnt[6:0];
                end
            end
            owed.push_back(res);
        endfunction

        // Compare one result transaction with the oldest outcome owed.
        task check(logic [1:0] status, logic [6:0] support);
            outcome_t want;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result status=%0d support=%0d", status, support));
                return;
            end
            want = owed.pop_front();
            if (status !== want.status)
                report($sformatf("status %0d, want %0d", status, want.status));
            if (support !== want.support)
                report($sformatf("support %0d, want %0d", support, want.support));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we;
    logic [9:0]  cfg_wdata;

    support_board board;
    bit           calm;      // set for a stretch with no idling on either side
    int unsigned  cycles;
    logic [9:0]   edge_a [$];
    logic [9:0]   edge_b [$];

    truss_adjacency_store_support_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #HALF_CLK;
        clk = 1'b1;
        #HALF_CLK;
    end

    // Abort the run if the block stops making progress.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("** truss_adjacency_store_support_core: FAILED **");
            $finish;
        end
    end

    // Result side: drop ready now and then, check every accepted transaction.
    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            m_axis_tready = calm || ($urandom_range(99) >= 8);
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                board.check(m_axis_tuser, m_axis_tdata[6:0]);
        end
    end

    // Drive one transaction on the input side; hold it until the block takes it.
    task send(logic [1:0] mode, logic [9:0] a, logic [9:0] b, logic [9:0] tn);
        while (!calm && $urandom_range(99) < 8) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = mode;
        s_axis_tdata  = {2'b00, tn, b, a};
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note(mode, a, b, tn);
        if ((mode == MODE_LOAD || mode == MODE_NEW) && board.owed[$].status == ST_OK) begin
            edge_a.push_back(a);
            edge_b.push_back(b);
        end
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Write the label register once the block has drained.
    task set_label(logic [9:0] value);
        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        board.max_label = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task random_phase(int base, int pool, int insert_pct);
        logic [1:0] mode;
        logic [9:0] a, b, tn;
        int         pick;
        edge_a.delete();
        edge_b.delete();
        repeat (PHASE_LEN) begin
            a  = 10'(base + $urandom_range(pool - 1));
            b  = 10'(base + $urandom_range(pool - 1));
            tn = 10'(($urandom_range(9) < 7) ? $urandom_range(6, 2) : $urandom_range(1023));
            if ($urandom_range(99) < insert_pct)
                mode = $urandom_range(1) ? MODE_NEW : MODE_LOAD;
            else begin
                mode = $urandom_range(1) ? MODE_PURE : MODE_MAX;
                if (edge_a.size() > 0 && $urandom_range(99) < 80) begin
                    pick = $urandom_range(edge_a.size() - 1);
                    a = edge_a[pick];
                    b = edge_b[pick];
                    if ($urandom_range(1))
                        {a, b} = {b, a};
                end
            end
            // Noise: endpoints anywhere in the vertex range.
            if ($urandom_range(99) < 4)
                a = 10'($urandom_range(1023));
            if ($urandom_range(99) < 4)
                b = 10'($urandom_range(1023));
            send(mode, a, b, tn);
        end
    endtask

    initial
    begin
        board = new();
        board.clear();
        cycles        = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_LOAD;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_label(10'd1000);

        // Directed: label clamps at load, a tied triangle, self-loops, missing edges.
        send(MODE_LOAD, 10'd0, 10'd1, 10'd0);
        send(MODE_LOAD, 10'd1, 10'd2, 10'd1);
        send(MODE_LOAD, 10'd0, 10'd2, 10'd1023);
        send(MODE_NEW,  10'd2, 10'd3, 10'd0);
        send(MODE_NEW,  10'd5, 10'd5, 10'd0);
        send(MODE_MAX,  10'd0, 10'd1, 10'd0);
        send(MODE_PURE, 10'd0, 10'd1, 10'd0);
        send(MODE_PURE, 10'd1, 10'd2, 10'd0);
        send(MODE_MAX,  10'd5, 10'd5, 10'd0);
        send(MODE_MAX,  10'd0, 10'd9, 10'd0);
        send(MODE_PURE, 10'd1023, 10'd1022, 10'd0);
        send(MODE_LOAD, 10'd1023, 10'd1022, 10'd512);
        send(MODE_MAX,  10'd1022, 10'd1023, 10'd0);
        send(MODE_LOAD, 10'd6, 10'd7, 10'd4);
        send(MODE_LOAD, 10'd7, 10'd8, 10'd4);
        send(MODE_LOAD, 10'd6, 10'd8, 10'd4);
        send(MODE_LOAD, 10'd6, 10'd9, 10'd4);
        send(MODE_LOAD, 10'd7, 10'd9, 10'd5);
        send(MODE_LOAD, 10'd8, 10'd9, 10'd6);
        send(MODE_PURE, 10'd6, 10'd7, 10'd0);
        send(MODE_MAX,  10'd7, 10'd6, 10'd0);
        send(MODE_PURE, 10'd8, 10'd9, 10'd0);

        // Random phases on disjoint vertex groups; the last crams three vertices full.
        for (int p = 0; p < PHASES; p++) begin
            set_label((p % 3 == 0) ? 10'd0 : (p % 3 == 1) ? 10'd1000
                                            : 10'($urandom_range(1000)));
            calm = (p == 2);
            if (p == PHASES - 1)
                random_phase(16 + p * 24, 3, 85);
            else
                random_phase(16 + p * 24, 10, 45);
        end
        calm = 1'b0;

        while (board.owed.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (board.errors == 0)
            $display("** truss_adjacency_store_support_core: PASSED **");
        else
            $display("** truss_adjacency_store_support_core: FAILED **");
        $finish;
    end

endmodule

>>> sim.f
rtl/tass_pkg.sv
rtl/tass_adj_mem.sv
rtl/truss_adjacency_store_support_core.sv
tb/tb_truss_adjacency_store_support_core.sv
